@@ rtl/swmm_pkg.sv @@
package swmm_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_WINDOW  = 256;
  localparam int unsigned POS_BITS    = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_BITS    = POS_BITS + 1;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_TAKE_MAXIMUM  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic shift_in;
    logic rotate;
  } chain_ctrl_t;

endpackage

@@ rtl/swmm_if.sv @@
interface swmm_in_if import swmm_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    end_of_series;

  modport source (output valid, output sample, output end_of_series, input ready);
  modport sink   (input valid, input sample, input end_of_series, output ready);
endinterface

interface swmm_out_if import swmm_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t extreme;
  logic    final_res;

  modport source (output valid, output extreme, output final_res, input ready);
  modport sink   (input valid, input extreme, input final_res, output ready);
endinterface

@@ rtl/sliding_window_min_max.sv @@
// Channel | Dir | Payload                       | Handshake
// in_i    | in  | sample[15:0], end_of_series   | valid/ready
// out_o   | out | extreme[15:0], final_res      | valid/ready
// cfg     | in  | cfg_idx_i, cfg_data_i[8:0]    | cfg_we_i, no wait
//
// An item that gives no result leaves the core idle and ready for the next item.
// An item that gives a result holds off input while the 256-cell ring rotates once
// through the single compare unit at its head, then the result loads the output register.
// Reset clears control and sets config defaults; sample cells have no reset and need none.
// A result that finds the output register full holds until out_o.ready frees it.
module sliding_window_min_max import swmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [LEN_BITS-1:0] cfg_data_i,
  swmm_in_if.sink          in_i,
  swmm_out_if.source       out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_WINDOW);

  logic [1:0]          state_d, state_q;
  logic [LEN_BITS-1:0] win_len_q;
  logic                take_max_q;
  logic [LEN_BITS-1:0] fill_d, fill_q;
  logic [LEN_BITS-1:0] n_d, n_q;
  logic                last_d, last_q;
  logic                mode_d, mode_q;
  logic [POS_BITS-1:0] cnt_d, cnt_q;
  sample_t             acc_d, acc_q;
  logic                out_valid_d, out_valid_q;
  sample_t             out_ext_d, out_ext_q;
  logic                out_fin_d, out_fin_q;

  logic                accept;
  logic [LEN_BITS-1:0] eff_len, fill_new;
  logic                full_win, emit, better, load_out;
  sample_t             head;
  chain_ctrl_t         chain_ctrl;

  swmm_chain u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (chain_ctrl),
    .sample_i (in_i.sample),
    .head_o   (head)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    eff_len = win_len_q;
    if (win_len_q == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (win_len_q > LEN_MAX) begin
      eff_len = LEN_MAX;
    end
    fill_new = (fill_q < LEN_MAX) ? fill_q + LEN_BITS'(1) : fill_q;
    full_win = (fill_new >= eff_len);
    emit     = full_win || in_i.end_of_series;
  end

  assign better   = mode_q ? (head > acc_q) : (head < acc_q);
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d             = state_q;
    fill_d              = fill_q;
    n_d                 = n_q;
    last_d              = last_q;
    mode_d              = mode_q;
    cnt_d               = cnt_q;
    acc_d               = acc_q;
    chain_ctrl.shift_in = 1'b0;
    chain_ctrl.rotate   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          chain_ctrl.shift_in = 1'b1;
          fill_d = in_i.end_of_series ? '0 : fill_new;
          n_d    = full_win ? eff_len : fill_new;
          last_d = in_i.end_of_series;
          mode_d = take_max_q;
          cnt_d  = '0;
          if (emit) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        chain_ctrl.rotate = 1'b1;
        cnt_d = cnt_q + POS_BITS'(1);
        if (({1'b0, cnt_q} < n_q) && ((cnt_q == '0) || better)) begin
          acc_d = head;
        end
        if (cnt_q == POS_BITS'(MAX_WINDOW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_ext_d   = out_ext_q;
    out_fin_d   = out_fin_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_ext_d   = acc_q;
      out_fin_d   = last_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      win_len_q   <= LEN_BITS'(16);
      take_max_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_LENGTH: win_len_q  <= cfg_data_i;
          REG_TAKE_MAXIMUM:  take_max_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    last_q    <= last_d;
    mode_q    <= mode_d;
    cnt_q     <= cnt_d;
    acc_q     <= acc_d;
    out_ext_q <= out_ext_d;
    out_fin_q <= out_fin_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.extreme   = out_ext_q;
  assign out_o.final_res = out_fin_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_MAX)
    else $error("fill count above window capacity");

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (n_q != '0) && (n_q <= LEN_MAX))
    else $error("scan length out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.end_of_series) |=> (fill_q == '0) && (state_q == ST_SCAN))
    else $error("series end did not clear state or start a scan");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished scan");

endmodule

@@ rtl/swmm_cell.sv @@
module swmm_cell import swmm_pkg::*; (
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  sample_t     lower_i,
  input  sample_t     upper_i,
  output sample_t     data_o
);

  sample_t data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_in) begin
      data_d = lower_i;
    end else if (ctrl_i.rotate) begin
      data_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/swmm_chain.sv @@
module swmm_chain import swmm_pkg::*; (
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  sample_t     sample_i,
  output sample_t     head_o
);

  sample_t cell_q [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    sample_t lower, upper;

    if (k == 0) begin : g_first
      assign lower = sample_i;
    end else begin : g_mid_lo
      assign lower = cell_q[k-1];
    end

    if (k == MAX_WINDOW - 1) begin : g_last
      assign upper = cell_q[0];
    end else begin : g_mid_hi
      assign upper = cell_q[k+1];
    end

    swmm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_q[k])
    );
  end

  assign head_o = cell_q[0];

endmodule

@@ sim/swmm_extreme_checker.sv @@
module swmm_extreme_checker import swmm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [LEN_BITS-1:0] cfg_data_i,
  swmm_in_if                  in_mon,
  swmm_out_if                 out_mon,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  typedef struct packed {
    sample_t extreme;
    logic    final_res;
  } window_result_t;

  window_result_t      expected_q[$];
  window_result_t      exp_res;
  sample_t             history[MAX_WINDOW];
  logic [POS_BITS-1:0] wr_pos;
  logic [LEN_BITS-1:0] series_fill;
  logic [LEN_BITS-1:0] win_len;
  logic                max_mode;
  int                  span;

  function automatic sample_t window_extreme(int n);
    logic [POS_BITS-1:0] pos;
    sample_t             best;
    pos  = wr_pos;
    best = '0;
    for (int i = 0; i < n; i++) begin
      pos = pos - 1'b1;
      if (i == 0 || (max_mode ? (history[pos] > best) : (history[pos] < best))) begin
        best = history[pos];
      end
    end
    return best;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      expected_q.delete();
      wr_pos       = '0;
      series_fill  = '0;
      win_len      = LEN_BITS'(16);
      max_mode     = 1'b0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: extreme %0d final_res %0b",
                 out_mon.extreme, out_mon.final_res);
          fail_count_o++;
        end else begin
          exp_res = expected_q.pop_front();
          checked_o++;
          if (out_mon.extreme !== exp_res.extreme) begin
            $error("extreme: expected %0d, got %0d", exp_res.extreme, out_mon.extreme);
            fail_count_o++;
          end
          if (out_mon.final_res !== exp_res.final_res) begin
            $error("final_res: expected %0b, got %0b", exp_res.final_res,
                   out_mon.final_res);
            fail_count_o++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        span = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
        history[wr_pos] = in_mon.sample;
        wr_pos = wr_pos + 1'b1;
        if (series_fill < MAX_WINDOW) begin
          series_fill = series_fill + 1'b1;
        end
        if (series_fill >= span) begin
          expected_q.push_back('{window_extreme(span), in_mon.end_of_series});
        end else if (in_mon.end_of_series) begin
          expected_q.push_back('{window_extreme(int'(series_fill)), 1'b1});
        end
        if (in_mon.end_of_series) begin
          wr_pos      = '0;
          series_fill = '0;
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_LENGTH: win_len  = cfg_data_i;
          REG_TAKE_MAXIMUM:  max_mode = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = expected_q.size();
  end

endmodule

@@ sim/tb_sliding_window_min_max.sv @@
module tb_sliding_window_min_max import swmm_pkg::*;;

  localparam int DRAIN_CYCLES = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_idx;
  logic [LEN_BITS-1:0] cfg_data;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  items_sent;
  int                  settings_used;
  int                  fail_count;
  int                  pending;
  int                  checked;

  swmm_in_if  in_if ();
  swmm_out_if out_if ();

  sliding_window_min_max uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  swmm_extreme_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #40_000_000;
    $display("FAIL sliding_window_min_max");
    $finish;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'(0);
      3:       return sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(input sample_t s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.sample        <= s;
    in_if.end_of_series <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int len, input bit maxm);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WINDOW_LENGTH;
    cfg_data <= LEN_BITS'(len);
    @(negedge clk_i);
    cfg_idx  <= REG_TAKE_MAXIMUM;
    cfg_data <= LEN_BITS'(maxm);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int len, input bit maxm, input int idle, input int stall,
                           input int budget, input bit allow_long);
    int w;
    int left;
    int n;
    settle();
    apply_setting(len, maxm);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    w    = (len == 0) ? 1 : ((len > MAX_WINDOW) ? MAX_WINDOW : len);
    left = budget;
    while (left > 0) begin
      if (w > 32 && !allow_long) begin
        n = $urandom_range(24, 1);
      end else if ($urandom_range(3) == 0) begin
        n = $urandom_range(w, 1);
      end else begin
        n = $urandom_range(w + 12, w);
      end
      for (int k = 0; k < n && left > 0; k++) begin
        push_sample(pick_sample(), k == n - 1);
        left--;
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_WINDOW_LENGTH;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.sample        = '0;
    in_if.end_of_series = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    items_sent          = 0;
    settings_used       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero-length window acts as pass-through
    apply_setting(0, 1'b0);
    push_sample(sample_t'(32767), 1'b0);
    push_sample(sample_t'(-32768), 1'b1);

    settle();
    apply_setting(1, 1'b1);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(16'h5555), 1'b0);
    push_sample(sample_t'(16'hAAAA), 1'b1);

    settle();
    apply_setting(3, 1'b0);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(-7), 1'b0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(32767), 1'b0);
    push_sample(sample_t'(-32768), 1'b1);
    push_sample(sample_t'(4), 1'b0);
    push_sample(sample_t'(9), 1'b1);
    push_sample(sample_t'(-5), 1'b1);

    // oversized length saturates; short series yields one closing result
    settle();
    apply_setting(300, 1'b1);
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(100), 1'b0);
    push_sample(sample_t'(-3), 1'b1);

    // change mode and length in the middle of a series
    settle();
    apply_setting(4, 1'b0);
    push_sample(sample_t'(-20), 1'b0);
    push_sample(sample_t'(50), 1'b0);
    push_sample(sample_t'(10), 1'b0);
    settle();
    apply_setting(2, 1'b1);
    push_sample(sample_t'(-30), 1'b1);

    run_phase(2,   1'b0, 0,  0,  90,  1'b0);
    run_phase(5,   1'b1, 86, 0,  90,  1'b0);
    run_phase(1,   1'b1, 0,  86, 90,  1'b0);
    run_phase(16,  1'b0, 15, 15, 90,  1'b0);
    run_phase(0,   1'b1, 0,  0,  60,  1'b0);
    run_phase(9,   1'b0, 0,  86, 100, 1'b0);
    run_phase(256, 1'b1, 0,  0,  262, 1'b1);
    run_phase(511, 1'b0, 86, 0,  40,  1'b0);
    run_phase(3,   1'b1, 15, 15, 100, 1'b0);
    run_phase(257, 1'b0, 0,  86, 30,  1'b0);
    run_phase(12,  1'b1, 86, 0,  100, 1'b0);

    settle();
    $display("Sent %0d samples under %0d window/mode settings, %0d window results checked.",
             items_sent, settings_used, checked);
    $display("Windows covered: 0, 1, 2, 3, 5, 9, 12, 16, 256 and oversized, min and max.");
    if (fail_count == 0) begin
      $display("PASS sliding_window_min_max");
    end else begin
      $display("FAIL sliding_window_min_max");
    end
    $finish;
  end

endmodule
